// File: design/keypad_code_entry_checker_defines.svh
// Assertion macros used by the keypad code entry checker assertion module
`ifndef KEYPAD_CODE_ENTRY_CHECKER_DEFINES_SVH
`define KEYPAD_CODE_ENTRY_CHECKER_DEFINES_SVH

// same-cycle implication, gated off during reset
`define KCEC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, gated off during reset
`define KCEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/kcec_pkg.sv
// Types and constants for the keypad code entry checker
`default_nettype none

package kcec_pkg;

    localparam int MAX_KEYS = 16;
    localparam int KEY_W    = 4;
    localparam int CNT_W    = 5;
    localparam int IDX_W    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CODE_W   = 64;
    localparam int LEN_W    = 5;

    localparam logic [KEY_W-1:0] KEY_A    = 4'd10;
    localparam logic [KEY_W-1:0] KEY_B    = 4'd11;
    localparam logic [KEY_W-1:0] KEY_C    = 4'd12;
    localparam logic [KEY_W-1:0] KEY_D    = 4'd13;
    localparam logic [KEY_W-1:0] KEY_HASH = 4'd15;

    // configuration register indexes
    localparam logic REG_STORED_CODE   = 1'b0;
    localparam logic REG_STORED_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_NONE     = 2'd0,
        VERDICT_MATCH    = 2'd1,
        VERDICT_MISMATCH = 2'd2,
        VERDICT_EMPTY    = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        verdict_t         verdict;
    } result_t;

endpackage

`default_nettype wire

// File: design/kcec_entry_core.sv
// Entry buffer, key decode and code compare
`default_nettype none

module kcec_entry_core
    import kcec_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [KEY_W-1:0]  key,
    input  wire logic [CODE_W-1:0] stored_code,
    input  wire logic [LEN_W-1:0]  stored_length,
    output result_t                result
);

    logic [KEY_W-1:0] entry_keys_reg [MAX_KEYS];
    logic [CNT_W-1:0] entry_count_reg;
    logic [CNT_W-1:0] entry_count_next;
    logic             key_wr;
    logic [MAX_KEYS-1:0] pos_ok;
    logic             codes_equal;
    verdict_t         verdict;

    // positions at or beyond the count are don't-care in the compare
    always_comb
    begin
        for (int i = 0; i < MAX_KEYS; i++)
        begin
            pos_ok[i] = (CNT_W'(i) >= entry_count_reg) ||
                        (entry_keys_reg[i] == stored_code[KEY_W*i +: KEY_W]);
        end
        codes_equal = (entry_count_reg == stored_length) && (&pos_ok);
    end

    always_comb
    begin
        entry_count_next = entry_count_reg;
        verdict          = VERDICT_NONE;
        key_wr           = 1'b0;
        case (key) inside
            KEY_A, KEY_B:
            begin
            end
            KEY_C:
            begin
                entry_count_next = '0;
            end
            KEY_D:
            begin
                if (entry_count_reg != '0)
                    entry_count_next = entry_count_reg - CNT_W'(1);
            end
            KEY_HASH:
            begin
                if (entry_count_reg == '0)
                    verdict = VERDICT_EMPTY;
                else if (codes_equal)
                    verdict = VERDICT_MATCH;
                else
                begin
                    verdict          = VERDICT_MISMATCH;
                    entry_count_next = '0;
                end
            end
            default:
            begin
                if (entry_count_reg < CNT_W'(MAX_KEYS))
                begin
                    key_wr           = 1'b1;
                    entry_count_next = entry_count_reg + CNT_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_count_reg <= '0;
        else if (step)
            entry_count_reg <= entry_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && key_wr)
            entry_keys_reg[entry_count_reg[IDX_W-1:0]] <= key;
    end

    assign result.verdict = verdict;
    assign result.count   = entry_count_next;

endmodule

`default_nettype wire

// File: design/keypad_code_entry_checker.sv
// Keypad code entry checker top level: stream ports, config registers, pipeline registers
//
// Takes one keypad key per transfer and answers each key with exactly one result
// (verdict and number of keys held). A key is registered on input, decoded and
// compared against the enrolled code combinationally, and the result is registered
// on output. A new key is taken every cycle while the output is not stalled. The
// entry count register, updated as each key advances, sets that rate. The output register
// decouples the sides: input keeps flowing while a result waits as long as the
// pipeline has a free slot. Config writes (index 0 code, index 1 length) are
// expected only while idle. There is no clearing pass after reset.
`default_nettype none

module keypad_code_entry_checker
    import kcec_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [3:0] key
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,   // [1:0] verdict, [6:2] entered_count
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [CODE_W-1:0] cfg_data
);

    logic              in_valid_reg;
    logic [KEY_W-1:0]  key_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;
    logic [CODE_W-1:0] stored_code_reg;
    logic [LEN_W-1:0]  stored_length_reg;
    logic              advance;
    result_t           result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_code_reg   <= '0;
            stored_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STORED_CODE:   stored_code_reg   <= cfg_data;
                REG_STORED_LENGTH: stored_length_reg <= cfg_data[LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            key_reg <= s_tdata[KEY_W-1:0];
        if (advance)
            out_data_reg <= result;
    end

    kcec_entry_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .key           (key_reg),
        .stored_code   (stored_code_reg),
        .stored_length (stored_length_reg),
        .result        (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg.count, out_data_reg.verdict};

endmodule

`default_nettype wire

// File: design/kcec_checker.sv
// Port-level assertions for the keypad code entry checker, bound to the top level
`default_nettype none

`include "keypad_code_entry_checker_defines.svh"

module kcec_checker
    import kcec_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    logic [1:0]       verdict;
    logic [CNT_W-1:0] count;

    assign verdict = m_tdata[1:0];
    assign count   = m_tdata[6:2];

    `KCEC_ASSERT_NOW(a_count_range, m_tvalid, count <= CNT_W'(MAX_KEYS), "count above max")
    `KCEC_ASSERT_NOW(a_mismatch_clears, m_tvalid && verdict == VERDICT_MISMATCH, count == '0, "mismatch kept keys")
    `KCEC_ASSERT_NOW(a_empty_zero, m_tvalid && verdict == VERDICT_EMPTY, count == '0, "empty verdict with keys")
    `KCEC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind keypad_code_entry_checker kcec_checker u_kcec_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: tb/keypad_code_entry_checker_test.sv
// Self-checking testbench for the keypad code entry checker
module keypad_code_entry_checker_test;
    import kcec_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [KEY_W-1:0] KEY_STAR = 4'd14;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        verdict_t         verdict;
        logic [CNT_W-1:0] count;
    } entry_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;       // [3:0] key
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;            // [1:0] verdict, [6:2] entered_count
    logic              cfg_we = 1'b0;
    logic              cfg_index = REG_STORED_CODE;
    logic [CODE_W-1:0] cfg_data = '0;

    // shadow of the lock state
    logic [CODE_W-1:0] code_word = '0;
    logic [LEN_W-1:0]  code_len = '0;
    logic [KEY_W-1:0]  held_keys [MAX_KEYS];
    logic [CNT_W-1:0]  held_count = '0;

    entry_result_t pending_results [$];
    int  keys_sent = 0;
    int  failures = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    bit  send_idle = 1'b0;
    bit  recv_idle = 1'b0;
    bit  long_hold_req = 1'b0;

    keypad_code_entry_checker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("keypad_code_entry_checker test failed");
            $finish;
        end
    end

    function automatic bit entry_matches();
        if (held_count != code_len)
            return 1'b0;
        for (int i = 0; i < MAX_KEYS; i++)
        begin
            if (CNT_W'(i) < held_count && held_keys[i] != code_word[4*i +: 4])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // updates the shadow state for one key and returns the result it causes
    function automatic entry_result_t advance_entry(input logic [KEY_W-1:0] k);
        entry_result_t r;
        r.verdict = VERDICT_NONE;
        case (k)
            KEY_A, KEY_B: ;
            KEY_C: held_count = '0;
            KEY_D:
            begin
                if (held_count != '0)
                    held_count = held_count - CNT_W'(1);
            end
            KEY_HASH:
            begin
                if (held_count == '0)
                    r.verdict = VERDICT_EMPTY;
                else if (entry_matches())
                    r.verdict = VERDICT_MATCH;
                else
                begin
                    r.verdict = VERDICT_MISMATCH;
                    held_count = '0;
                end
            end
            default:
            begin
                // full buffer drops the key
                if (held_count < CNT_W'(MAX_KEYS))
                begin
                    held_keys[held_count[3:0]] = k;
                    held_count = held_count + CNT_W'(1);
                end
            end
        endcase
        r.count = held_count;
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] random_entry_key();
        int r;
        r = $urandom_range(0, 10);
        return (r == 10) ? KEY_STAR : 4'(r);
    endfunction

    function automatic logic [CODE_W-1:0] random_entry_code();
        logic [CODE_W-1:0] c;
        for (int i = 0; i < MAX_KEYS; i++)
            c[4*i +: 4] = random_entry_key();
        return c;
    endfunction

    // output side: random stalls per transfer, plus a long hold on request
    always @(posedge clk or negedge rst_n)
    begin
        int gap;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end
        else if (long_hold_req)
        begin
            m_tready <= 1'b0;
            stall_left <= LONG_HOLD_CYCLES;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= (stall_left == 1);
        end
        else if (m_tvalid && m_tready)
        begin
            gap = recv_idle ? int'($urandom_range(0, 9)) : 0;
            stall_left <= gap;
            m_tready <= (gap == 0);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        entry_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected: verdict %0d count %0d",
                       m_tdata[1:0], m_tdata[6:2]);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] != want.verdict)
                begin
                    $error("verdict: expected %0d, got %0d", want.verdict, m_tdata[1:0]);
                    failures++;
                end
                if (m_tdata[6:2] != want.count)
                begin
                    $error("entered_count: expected %0d, got %0d", want.count, m_tdata[6:2]);
                    failures++;
                end
            end
        end
    end

    task automatic send_key(input logic [KEY_W-1:0] k);
        int gap;
        gap = send_idle ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0000, k};
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(advance_entry(k));
        keys_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // both registers in back-to-back cycles; the block is idle here
    task automatic write_lock(input logic [CODE_W-1:0] code, input logic [CODE_W-1:0] len_word);
        cfg_we <= 1'b1;
        cfg_index <= REG_STORED_CODE;
        cfg_data <= code;
        @(posedge clk);
        cfg_index <= REG_STORED_LENGTH;
        cfg_data <= len_word;
        @(posedge clk);
        cfg_we <= 1'b0;
        code_word = code;
        code_len = len_word[LEN_W-1:0];
    endtask

    // reset config: zero length, so any non-empty entry mismatches
    task automatic test_control_keys();
        send_key(KEY_HASH);
        send_key(KEY_D);
        send_key(KEY_A);
        send_key(KEY_B);
        send_key(4'd9);
        send_key(KEY_HASH);
        send_key(KEY_STAR);
        send_key(KEY_C);
    endtask

    task automatic test_full_entry();
        logic [CODE_W-1:0] code;
        code = random_entry_code();
        code[3:0] = 4'd0;
        drain_results();
        write_lock(code, 64'd16);
        for (int i = 0; i < MAX_KEYS; i++)
            send_key(code[4*i +: 4]);
        send_key(KEY_STAR);
        send_key(KEY_HASH);
        send_key(KEY_D);
        send_key(KEY_HASH);
    endtask

    task automatic test_output_backpressure();
        send_idle = 1'b0;
        drain_results();
        long_hold_req <= 1'b1;
        @(posedge clk);
        long_hold_req <= 1'b0;
        for (int i = 0; i < 40; i++)
            send_key(4'($urandom_range(0, 15)));
        drain_results();
    endtask

    task automatic send_attempt();
        int pick;
        int n;
        logic [KEY_W-1:0] k;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            // entry of the enrolled code (untypable keys replaced at random), sometimes with a fixed typo
            if ($urandom_range(0, 3) != 0)
                send_key(KEY_C);
            n = (code_len > LEN_W'(MAX_KEYS)) ? MAX_KEYS : int'(code_len);
            for (int i = 0; i < n; i++)
            begin
                k = code_word[4*i +: 4];
                if (k > 4'd9 && k != KEY_STAR)
                    k = random_entry_key();
                if ($urandom_range(0, 15) == 0)
                begin
                    send_key(random_entry_key());
                    send_key(KEY_D);
                end
                send_key(k);
            end
            send_key(KEY_HASH);
            if ($urandom_range(0, 2) == 0)
                send_key(KEY_HASH);
        end
        else if (pick < 85)
        begin
            n = $urandom_range(0, 18);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 9))
                    0: send_key(KEY_D);
                    1: send_key(KEY_C);
                    default: send_key(random_entry_key());
                endcase
            end
            send_key(KEY_HASH);
        end
        else
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                send_key(4'($urandom_range(0, 15)));
        end
    endtask

    task automatic test_random_phases();
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] len_word;
        logic [LEN_W-1:0]  len;
        int target;
        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0: begin code = '0; len = 5'd0; end
                1: begin code = '1; len = 5'd16; end
                2: begin code = random_entry_code(); len = 5'd31; end
                3: begin code = random_entry_code(); len = 5'd17; end
                4: begin code = '0; len = 5'd16; end
                5: begin code = random_entry_code(); len = 5'd1; end
                6: begin code = {$urandom, $urandom}; len = 5'($urandom_range(1, 16)); end
                default: begin code = random_entry_code(); len = 5'($urandom_range(2, 16)); end
            endcase
            // upper bits of the length word are don't-care
            len_word = {$urandom, $urandom};
            if (p % 2 == 0)
                len_word = '0;
            len_word[LEN_W-1:0] = len;
            drain_results();
            write_lock(code, len_word);
            send_idle = 1'($urandom_range(0, 1));
            recv_idle <= 1'($urandom_range(0, 1));
            target = keys_sent + 150;
            while (keys_sent < target)
                send_attempt();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        recv_idle <= 1'b1;
        send_idle = 1'b1;
        test_control_keys();
        test_full_entry();
        test_output_backpressure();
        test_random_phases();
        drain_results();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("keypad_code_entry_checker test passed");
        else
            $display("keypad_code_entry_checker test failed");
        $finish;
    end
endmodule
